/* rtl/assert_macros.svh */
// Assertion helpers shared by the velocity estimator files.
// Each macro checks on the rising clock edge and stays quiet while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/emv_pkg.sv */
`default_nettype none

package emv_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int CAP_W          = 16;
	localparam int DELTA_W        = 16;
	localparam int FACTOR_W       = 32;
	localparam int PROD_W         = DELTA_W + FACTOR_W;
	localparam int OVF_W          = 8;
	localparam int VEL_W          = 32;
	localparam int CFG_W          = 32;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET  = 32'd5000000;
	localparam logic [OVF_W-1:0]    TIMEOUT_RESET = 8'd10;
	localparam logic [OVF_W-1:0]    OVF_MAX       = 8'd255;

	typedef enum logic [1:0] {
		KIND_CAPTURE  = 2'd0,
		KIND_OVERFLOW = 2'd1,
		KIND_REQUEST  = 2'd2
	} kind_t;

	typedef enum logic {
		REG_VELOCITY_FACTOR   = 1'b0,
		REG_TIMEOUT_OVERFLOWS = 1'b1
	} reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_PUT
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [CAP_W-1:0]   capture_value;
		logic [DELTA_W-1:0] pulse_count;
	} item_t;

	typedef struct packed {
		logic signed [VEL_W-1:0] velocity;
		logic                    timed_out;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

/* rtl/encoder_mt_velocity.sv */
// Hybrid M/T encoder velocity estimator.
// Capture and overflow words are taken while idle; item_ready stays high for the next word.
// A moving request passes S_MUL (the multiply), then the one-bit-per-cycle divider; the
// quotient is latched as the divider finishes, and S_PUT loads it once the result is free.
// Other requests go straight to S_PUT; input reopens only once the result loads.
// arst_n clears the control and measurement state and loads the register defaults; the estimator starts stopped.
`default_nettype none

`include "assert_macros.svh"

module encoder_mt_velocity
	import emv_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// input words
	input  wire logic             item_valid,
	output      logic             item_ready,
	input  wire item_t            item,
	// result words
	output      logic             result_valid,
	input  wire logic             result_ready,
	output      result_t          result,
	// register writes
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	// Stored capture width: the timer value never has more bits than the field.
	localparam int CW = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
	// Elapsed time in two's complement; the positive range fits DW bits.
	localparam int DW = TIMER_BITS + OVF_W;
	localparam int EW = DW + 1;

	localparam logic [VEL_W-1:0]  VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0]  VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic [PROD_W-1:0] Q_POS_LIM = PROD_W'(VEL_MAX);
	localparam logic [PROD_W-1:0] Q_NEG_LIM = PROD_W'(VEL_MIN);

	// configuration
	logic [FACTOR_W-1:0] factor_q;
	logic [OVF_W-1:0]    timeout_q;

	// measurement state
	logic [CW-1:0]      newest_q;
	logic [CW-1:0]      prev_cap_q;
	logic [DELTA_W-1:0] prev_count_q;
	logic [OVF_W-1:0]   ovf_q;
	logic               stopped_q;

	// request in flight
	state_t             state_q, state_d;
	logic [DELTA_W-1:0] mag_q;
	logic               neg_q;
	logic [DW-1:0]      divisor_q;
	result_t            res_q;

	// result register
	logic    out_valid_q;
	result_t out_q;

	// request decode
	logic               accept;
	logic               is_req;
	logic [DELTA_W-1:0] diff;
	logic               delta_zero;
	logic               delta_neg;
	logic [DELTA_W-1:0] delta_mag;
	logic [EW-1:0]      elapsed;
	logic               elapsed_pos;
	logic               timed_out_now;
	logic               needs_div;

	// divider hookup
	logic              div_start;
	logic [PROD_W-1:0] product;
	div_stat_t         div_stat;
	logic [PROD_W-1:0] div_quot;
	logic [VEL_W-1:0]  vel_sat;
	logic              put_fire;

	assign cfg_ready = 1'b1;

	assign accept = item_valid && item_ready;
	assign is_req = (item.kind == KIND_REQUEST);

	// Signed pulse delta: 16-bit wrap, taken apart into sign and magnitude.
	assign diff       = item.pulse_count - prev_count_q;
	assign delta_zero = (diff == '0);
	assign delta_neg  = diff[DELTA_W-1];
	assign delta_mag  = delta_neg ? (~diff + 1'b1) : diff;

	// Elapsed capture time: whole timer periods plus the capture difference.
	assign elapsed = {1'b0, ovf_q, {TIMER_BITS{1'b0}}}
		+ EW'(newest_q) - EW'(prev_cap_q);
	assign elapsed_pos   = !elapsed[EW-1] && (elapsed != '0);
	assign timed_out_now = (ovf_q >= timeout_q);
	assign needs_div     = !delta_zero && !stopped_q && elapsed_pos;

	// One 16 x 32 multiply feeding the divider, latched at its start.
	assign product = PROD_W'(mag_q) * PROD_W'(factor_q);

	emv_div #(
		.DVD_W(PROD_W),
		.DSR_W(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(product),
		.divisor (divisor_q),
		.stat    (div_stat),
		.quotient(div_quot)
	);

	// Saturate the magnitude quotient and restore the sign.
	always_comb begin
		if (!neg_q) begin
			vel_sat = (div_quot > Q_POS_LIM) ? VEL_MAX : div_quot[VEL_W-1:0];
		end else begin
			vel_sat = (div_quot > Q_NEG_LIM) ? VEL_MIN : (~div_quot[VEL_W-1:0] + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		div_start  = 1'b0;
		put_fire   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && is_req) begin
					state_d = needs_div ? S_MUL : S_PUT;
				end
			end
			S_MUL: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_stat.done) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				// hold until the result register is free
				if (!out_valid_q || result_ready) begin
					put_fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// configuration and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q     <= FACTOR_RESET;
			timeout_q    <= TIMEOUT_RESET;
			newest_q     <= '0;
			prev_cap_q   <= '0;
			prev_count_q <= '0;
			ovf_q        <= '0;
			stopped_q    <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_VELOCITY_FACTOR:   factor_q  <= cfg_data[FACTOR_W-1:0];
					REG_TIMEOUT_OVERFLOWS: timeout_q <= cfg_data[OVF_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				unique case (item.kind)
					KIND_CAPTURE: begin
						newest_q <= item.capture_value[CW-1:0];
					end
					KIND_OVERFLOW: begin
						// saturate the period count
						if (ovf_q != OVF_MAX) begin
							ovf_q <= ovf_q + 1'b1;
						end
					end
					KIND_REQUEST: begin
						if (delta_zero) begin
							if (timed_out_now) begin
								stopped_q <= 1'b1;
							end
						end else begin
							// consume: advance the reference
							prev_count_q <= item.pulse_count;
							prev_cap_q   <= newest_q;
							ovf_q        <= '0;
							stopped_q    <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept && is_req) begin
			mag_q           <= delta_mag;
			neg_q           <= delta_neg;
			divisor_q       <= elapsed[DW-1:0];
			res_q.velocity  <= '0;
			res_q.timed_out <= delta_zero && timed_out_now;
		end else if (state_q == S_DIV && div_stat.done) begin
			res_q.velocity  <= vel_sat;
			res_q.timed_out <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_fire) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`ASSERT_CLK(a_idle_divider, item_ready |-> !div_stat.busy, "input open while dividing")
	`ASSERT_CLK(a_done_in_div, div_stat.done |-> (state_q == S_DIV), "divider done out of turn")
	`ASSERT_CLK(a_timeout_zero, result_valid |-> (!result.timed_out || result.velocity == '0), "timeout with nonzero velocity")

endmodule

`default_nettype wire

/* rtl/emv_div.sv */
`default_nettype none

`include "assert_macros.svh"

module emv_div
	import emv_pkg::*;
#(
	parameter int DVD_W = PROD_W,
	parameter int DSR_W = TIMER_BITS_DEF + OVF_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DSR_W-1:0] divisor,
	output      div_stat_t        stat,
	output      logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0] rem_sh;
	logic [DSR_W:0] trial;
	logic           fits;

	// one restoring step: shift in the next dividend bit, try the subtract
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign trial  = rem_sh - {1'b0, dsr_q};
	assign fits   = !trial[DSR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

	`ASSERT_CLK(a_done_after_busy, done_q |-> $past(busy_q), "divider done without a run")
	`ASSERT_NEVER(a_start_while_busy, start && busy_q, "divider restarted mid-run")
	`ASSERT_NEVER(a_done_and_busy, done_q && busy_q, "divider done while still running")

endmodule

`default_nettype wire
